// ===== rtl/core/uarttq_pkg.sv =====
// ----------------------------------------------------------------------------
// UART transmit queue package
// Shared types, constants and pointer helpers for the transmit queue block.
// ----------------------------------------------------------------------------
package uarttq_pkg;

  // Number of byte entries in the transmit queue.
  localparam int unsigned QUEUE_DEPTH = 256;
  // Pointers count modulo twice the depth so that full and empty differ.
  localparam int unsigned PTR_W = $clog2(2 * QUEUE_DEPTH);
  localparam int unsigned IDX_W = $clog2(QUEUE_DEPTH);

  localparam int unsigned NUM_DIGITS = 5;
  localparam int unsigned FILL_W = 9;

  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [1:0] {
    CMD_PUT_CHAR = 2'd0,
    CMD_PUT_NUM  = 2'd1,
    CMD_TX_EMPTY = 2'd2,
    CMD_NOP      = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_PUSH,
    ST_READ
  } state_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  char_byte;
    logic        first_of_message;
    logic        last_of_message;
    logic [15:0] number;
  } in_item_t;

  typedef struct packed {
    logic              send_valid;
    logic [7:0]        send_byte;
    logic              tx_irq_enable;
    logic [FILL_W-1:0] fill_level;
    logic              dropped;
  } out_item_t;

  // Status of the decimal digit unit.
  typedef struct packed {
    logic                       done;
    logic [2:0]                 count;
    logic [NUM_DIGITS-1:0][3:0] digits;
  } dig_stat_t;

  // The last pointer value wraps back to zero.
  function automatic ptr_t ptr_next(ptr_t p);
    ptr_t n;
    if (p == ptr_t'(2 * QUEUE_DEPTH - 1)) begin
      n = '0;
    end else begin
      n = p + ptr_t'(1);
    end
    return n;
  endfunction

  function automatic idx_t ptr_index(ptr_t p);
    ptr_t r;
    r = (p >= ptr_t'(QUEUE_DEPTH)) ? p - ptr_t'(QUEUE_DEPTH) : p;
    return r[IDX_W-1:0];
  endfunction

  function automatic ptr_t fill_count(ptr_t wp, ptr_t rp);
    ptr_t f;
    if (wp >= rp) begin
      f = wp - rp;
    end else begin
      f = wp + ptr_t'(2 * QUEUE_DEPTH - 32'(rp));
    end
    return f;
  endfunction

endpackage

// ===== rtl/core/uarttq_ram.sv =====
// ----------------------------------------------------------------------------
// UART transmit queue RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module uarttq_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/uarttq_digits.sv =====
// ----------------------------------------------------------------------------
// UART transmit queue decimal digit unit
// Splits a 16-bit value into decimal digits, least significant first, one
// digit per cycle by multiplication with the reciprocal of ten.
// ----------------------------------------------------------------------------
module uarttq_digits
  import uarttq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [15:0] value_i,
  output dig_stat_t   stat_o
);

  // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x.
  localparam logic [31:0] DIV10_MUL = 32'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  logic                       busy_q, busy_d;
  logic                       done_q, done_d;
  logic [2:0]                 cnt_q, cnt_d;
  logic [15:0]                val_q;
  logic [NUM_DIGITS-1:0][3:0] dig_q;

  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] rem;

  always_comb begin
    prod = {16'b0, val_q} * DIV10_MUL;
    quot = 16'(prod >> DIV10_SHIFT);
    rem  = val_q - ((quot << 3) + (quot << 1));
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
    end else if (busy_q) begin
      cnt_d = cnt_q + 3'd1;
      if (quot == 16'd0 || cnt_q == 3'(NUM_DIGITS - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q <= value_i;
    end else if (busy_q) begin
      val_q        <= quot;
      dig_q[cnt_q] <= rem[3:0];
    end
  end

  assign stat_o.done   = done_q;
  assign stat_o.count  = cnt_q;
  assign stat_o.digits = dig_q;

endmodule

// ===== rtl/core/uart_transmit_queue_with_restart_core.sv =====
// ----------------------------------------------------------------------------
// UART transmit queue with restart
// Byte ring queue in front of a serial transmitter, fed by characters or by
// 16-bit numbers formatted as decimal text, drained by transmitter-empty events.
// ----------------------------------------------------------------------------
//
//   Channel  Signals                     Handshake
//   -------  --------------------------  ----------------------------------
//   input    start_i, in_item_i, busy_o  item taken when start_i && !busy_o
//   result   out_valid_o, out_item_o     one-cycle strobe, always taken
//
// A character item, an empty event on an empty queue, a number item that
// finds the queue full and the unused command complete in the idle state, so
// busy_o stays low and a new item can follow at once. An empty event that
// sends a byte also passes through ST_READ, because the queue RAM read is
// registered. A number with n decimal digits keeps busy_o high until its
// last write: n steps in the digit unit, the handoff from ST_CONV to ST_PUSH,
// then n+2 writes through the single RAM write port. Each result appears on
// the cycle after its item completes. Reset leaves the queue empty, restart
// pending and the interrupt disabled; the RAM contents need no clearing.
//
module uart_transmit_queue_with_restart_core
  import uarttq_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  input  in_item_t  in_item_i,
  output logic      busy_o,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  state_e    state_q, state_d;
  ptr_t      wp_q, wp_d;
  ptr_t      rp_q, rp_d;
  logic      restart_q, restart_d;
  logic      irq_q, irq_d;
  logic      msgdrop_q, msgdrop_d;
  logic      drop_q, drop_d;
  logic [2:0] pos_q, pos_d;
  logic      valid_q, valid_d;
  out_item_t res_q, res_d;

  logic      accept;
  logic      full;
  logic      ram_we;
  logic [7:0] ram_wdata;
  logic      ram_re;
  logic [7:0] ram_rdata;
  logic      dig_start;
  dig_stat_t dig_stat;

  // Digit selection during the number write sequence.
  logic [2:0] dig_idx;
  logic [3:0] dig_val;
  logic       drop_now;
  logic       dropping_eff;

  assign busy_o = (state_q != ST_IDLE);
  assign accept = start_i && !busy_o;
  assign full   = (fill_count(wp_q, rp_q) >= ptr_t'(QUEUE_DEPTH));

  uarttq_ram #(
    .DEPTH(QUEUE_DEPTH),
    .WIDTH(8)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ptr_index(wp_q)),
    .wdata_i(ram_wdata),
    .re_i   (ram_re),
    .raddr_i(ptr_index(rp_q)),
    .rdata_o(ram_rdata)
  );

  uarttq_digits u_digits (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(dig_start),
    .value_i(in_item_i.number),
    .stat_o (dig_stat)
  );

  assign dig_idx = (dig_stat.count - 3'd1) - pos_q;
  assign dig_val = dig_stat.digits[dig_idx];

  always_comb begin
    state_d   = state_q;
    wp_d      = wp_q;
    rp_d      = rp_q;
    restart_d = restart_q;
    irq_d     = irq_q;
    msgdrop_d = msgdrop_q;
    drop_d    = drop_q;
    pos_d     = pos_q;
    valid_d   = 1'b0;
    ram_we    = 1'b0;
    ram_wdata = in_item_i.char_byte;
    ram_re    = 1'b0;
    dig_start = 1'b0;
    drop_now  = 1'b0;
    dropping_eff = msgdrop_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item_i.cmd)
            CMD_PUT_CHAR: begin
              // A first mark re-decides whether the whole message is dropped.
              dropping_eff = in_item_i.first_of_message ? full : msgdrop_q;
              if (dropping_eff) begin
                drop_now = 1'b1;
              end else begin
                if (full) begin
                  drop_now = 1'b1;
                end else begin
                  ram_we = 1'b1;
                  wp_d   = ptr_next(wp_q);
                end
                if (in_item_i.last_of_message && restart_q) begin
                  restart_d = 1'b0;
                  irq_d     = 1'b1;
                end
              end
              msgdrop_d = in_item_i.last_of_message ? 1'b0 : dropping_eff;
              valid_d   = 1'b1;
            end
            CMD_PUT_NUM: begin
              if (full) begin
                drop_now = 1'b1;
                valid_d  = 1'b1;
              end else begin
                dig_start = 1'b1;
                drop_d    = 1'b0;
                pos_d     = '0;
                state_d   = ST_CONV;
              end
            end
            CMD_TX_EMPTY: begin
              if (wp_q != rp_q) begin
                ram_re    = 1'b1;
                rp_d      = ptr_next(rp_q);
                restart_d = 1'b0;
                state_d   = ST_READ;
              end else begin
                irq_d     = 1'b0;
                restart_d = 1'b1;
                valid_d   = 1'b1;
              end
            end
            CMD_NOP: begin
              valid_d = 1'b1;
            end
            default: begin
              valid_d = 1'b1;
            end
          endcase
        end
      end
      ST_CONV: begin
        if (dig_stat.done) begin
          state_d = ST_PUSH;
        end
      end
      ST_PUSH: begin
        // Sequence: digits most significant first, then CR, then LF.
        if (pos_q < dig_stat.count) begin
          ram_wdata = CHAR_ZERO + {4'b0, dig_val};
        end else if (pos_q == dig_stat.count) begin
          ram_wdata = CHAR_CR;
        end else begin
          ram_wdata = CHAR_LF;
        end
        if (full) begin
          drop_d = 1'b1;
        end else begin
          ram_we = 1'b1;
          wp_d   = ptr_next(wp_q);
        end
        pos_d = pos_q + 3'd1;
        if (pos_q == dig_stat.count + 3'd1) begin
          drop_now = full || drop_q;
          if (restart_q) begin
            restart_d = 1'b0;
            irq_d     = 1'b1;
          end
          valid_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      ST_READ: begin
        valid_d = 1'b1;
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    res_d.send_valid    = (state_q == ST_READ);
    res_d.send_byte     = (state_q == ST_READ) ? ram_rdata : 8'h00;
    res_d.tx_irq_enable = irq_d;
    res_d.fill_level    = FILL_W'(fill_count(wp_d, rp_d));
    res_d.dropped       = drop_now;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      restart_q <= 1'b1;
      irq_q     <= 1'b0;
      msgdrop_q <= 1'b0;
      drop_q    <= 1'b0;
      pos_q     <= '0;
      valid_q   <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      restart_q <= restart_d;
      irq_q     <= irq_d;
      msgdrop_q <= msgdrop_d;
      drop_q    <= drop_d;
      pos_q     <= pos_d;
      valid_q   <= valid_d;
    end
  end

  // Result payload is captured only when a result is produced.
  always_ff @(posedge clk_i) begin
    if (valid_d) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_item_o  = res_q;

endmodule
